// ===== rtl/swfr_pkg.sv =====
// package for the sync word frame receiver
// shared constants, state enum, command and status structs, sync byte function; no dependencies
package swfr_pkg;

   localparam int PACKET_LEN = 19;

   localparam int HELD_W    = 5;
   localparam int IDLE_W    = 16;
   localparam int STORE_AW  = $clog2(PACKET_LEN);
   localparam int RSP_DW    = 24;

   localparam logic [HELD_W-1:0] PKT_LEN_C  = HELD_W'(PACKET_LEN);
   localparam logic [HELD_W-1:0] PKT_LAST_C = HELD_W'(PACKET_LEN - 1);
   localparam logic [HELD_W-1:0] SYNC_LEN_C = HELD_W'(3);

   localparam logic [23:0]       SYNC_WORD   = 24'h550100;
   localparam logic [7:0]        SYNC_B0     = 8'h55;
   localparam logic [7:0]        SYNC_B1     = 8'h01;
   localparam logic [7:0]        SYNC_B2     = 8'h00;
   localparam logic [IDLE_W-1:0] IDLE_MAX    = 16'hffff;
   localparam logic [IDLE_W-1:0] TIMEOUT_RST = 16'd100;

   // request opcode
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // result kind
   localparam logic EV_FRAME_BYTE = 1'b0;
   localparam logic EV_DISCARD    = 1'b1;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic accept;     // request taken this cycle
      logic load_next;  // current result taken, load the following frame byte
   } command_type;

   typedef struct packed {
      logic emit_frame;    // request completes a frame
      logic emit_discard;  // request times out a partial frame
      logic out_last;      // result in the output register ends the run
   } status_type;

   // fixed leading bytes of every frame
   function automatic logic [7:0] sync_byte(input logic [HELD_W-1:0] idx);
      logic [7:0] b;
      case (idx)
         5'd0:    b = SYNC_B0;
         5'd1:    b = SYNC_B1;
         default: b = SYNC_B2;
      endcase
      return b;
   endfunction

endpackage

// ===== rtl/swfr_ctrl.sv =====
// controller state machine of the sync word frame receiver
// depends on swfr_pkg
module swfr_ctrl import swfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  status_type  status,
   output command_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && (status.emit_frame || status.emit_discard)) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (rsp_tready && status.out_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      cmd.accept    = 1'b0;
      cmd.load_next = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_SEND: begin
            rsp_tvalid    = 1'b1;
            cmd.load_next = rsp_tready && !status.out_last;
         end
         default: ;
      endcase
   end

endmodule

// ===== rtl/swfr_datapath.sv =====
// datapath of the sync word frame receiver: history, counters, frame store,
// timeout register and result register; depends on swfr_pkg
module swfr_datapath import swfr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data,
   input  logic              req_opcode,
   input  logic [7:0]        req_byte,
   input  command_type       cmd,
   output status_type        status,
   output logic              out_kind,
   output logic [HELD_W-1:0] out_idx,
   output logic [7:0]        out_val,
   output logic [HELD_W-1:0] out_held,
   output logic              out_last
);

   logic [23:0]       hist_ff, hist_in;
   logic              cap_ff, cap_in;
   logic [HELD_W-1:0] held_ff, held_in;
   logic [IDLE_W-1:0] idle_ff, idle_in;
   logic [IDLE_W-1:0] timeout_ff;
   logic [7:0]        store_ff [PACKET_LEN];

   logic              kind_ff;
   logic [HELD_W-1:0] idx_ff;
   logic [7:0]        val_ff;
   logic [HELD_W-1:0] oheld_ff;
   logic              last_ff;

   logic              is_tick;
   logic [IDLE_W-1:0] idle_inc;
   logic [HELD_W-1:0] held_inc;
   logic [23:0]       hist_new;
   logic              sync_hit;
   logic              sync_char;
   logic              store_wr;
   logic [HELD_W-1:0] nidx;
   logic [7:0]        nval;

   assign is_tick   = (req_opcode == OP_TICK);
   assign idle_inc  = (idle_ff == IDLE_MAX) ? idle_ff : idle_ff + IDLE_W'(1);
   assign held_inc  = held_ff + HELD_W'(1);
   assign hist_new  = {hist_ff[15:0], req_byte};
   assign sync_hit  = (hist_new == SYNC_WORD);
   assign sync_char = (req_byte == SYNC_B0) || (req_byte == SYNC_B1) ||
                      (req_byte == SYNC_B2);

   assign status.emit_discard = is_tick && cap_ff && (idle_inc > timeout_ff);
   assign status.emit_frame   = !is_tick && cap_ff && !sync_hit && (held_inc >= PKT_LEN_C);
   assign status.out_last     = last_ff;

   assign store_wr = cmd.accept && !is_tick && cap_ff && (held_ff < PKT_LEN_C);

   // next frame byte for the result register; leading bytes are the sync word
   assign nidx = idx_ff + HELD_W'(1);
   assign nval = (nidx < SYNC_LEN_C) ? sync_byte(nidx) : store_ff[nidx[STORE_AW-1:0]];

   always_comb begin
      hist_in = hist_ff;
      cap_in  = cap_ff;
      held_in = held_ff;
      idle_in = idle_ff;
      if (cmd.accept) begin
         if (is_tick) begin
            idle_in = idle_inc;
            if (status.emit_discard) begin
               cap_in  = 1'b0;
               held_in = '0;
            end
         end else begin
            idle_in = '0;
            if (!cap_ff) begin
               if (sync_char) begin
                  hist_in = hist_new;
                  if (sync_hit) begin
                     held_in = SYNC_LEN_C;
                     cap_in  = 1'b1;
                  end
               end else begin
                  held_in = '0;
               end
            end else begin
               hist_in = hist_new;
               if (sync_hit) begin
                  held_in = SYNC_LEN_C;
               end else if (held_inc >= PKT_LEN_C) begin
                  cap_in  = 1'b0;
                  held_in = '0;
               end else begin
                  held_in = held_inc;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff    <= '0;
         cap_ff     <= 1'b0;
         held_ff    <= '0;
         idle_ff    <= '0;
         timeout_ff <= TIMEOUT_RST;
      end else begin
         hist_ff <= hist_in;
         cap_ff  <= cap_in;
         held_ff <= held_in;
         idle_ff <= idle_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_ff[held_ff[STORE_AW-1:0]] <= req_byte;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.accept && status.emit_discard) begin
         kind_ff  <= EV_DISCARD;
         idx_ff   <= '0;
         val_ff   <= '0;
         oheld_ff <= held_ff;
         last_ff  <= 1'b1;
      end else if (cmd.accept && status.emit_frame) begin
         kind_ff  <= EV_FRAME_BYTE;
         idx_ff   <= '0;
         val_ff   <= sync_byte('0);
         oheld_ff <= '0;
         last_ff  <= 1'b0;
      end else if (cmd.load_next) begin
         idx_ff  <= nidx;
         val_ff  <= nval;
         last_ff <= (nidx == PKT_LAST_C);
      end
   end

   assign out_kind = kind_ff;
   assign out_idx  = idx_ff;
   assign out_val  = val_ff;
   assign out_held = oheld_ff;
   assign out_last = last_ff;

endmodule

// ===== rtl/sync_word_frame_receiver_core.sv =====
// top level of the sync word frame receiver: controller plus datapath
// depends on swfr_pkg, swfr_ctrl, swfr_datapath
// results: a request that completes a frame or times one out shows its first
//   result in the cycle after it is taken; any other request leaves the core idle
// throughput: one request at a time; a frame streams one byte per cycle while
//   rsp_tready is high, and a frame of PACKET_LEN = 19 bytes holds off requests
// reset: synchronous, active high; clears history, counters and state machine,
//   loads the timeout with 100; the frame store needs no clearing
module sync_word_frame_receiver_core import swfr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // configuration: idle timeout in ticks
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data,
   // request channel
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] rx_byte
   input  logic [0:0]        req_tuser,   // [0] opcode
   // result channel
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_DW-1:0] rsp_tdata,   // [4:0] byte_index, [12:5] byte_value,
                                          // [17:13] held_count, [23:18] zero
   output logic [0:0]        rsp_tuser,   // [0] event_kind
   output logic              rsp_tlast    // last
);

   command_type       cmd;
   status_type        status;
   logic              out_kind;
   logic [HELD_W-1:0] out_idx;
   logic [7:0]        out_val;
   logic [HELD_W-1:0] out_held;
   logic              out_last;

   // state machine: takes requests while idle, streams results otherwise
   swfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // sync hunt, capture, idle timer and frame store
   swfr_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_opcode  (req_tuser[0]),
      .req_byte    (req_tdata),
      .cmd         (cmd),
      .status      (status),
      .out_kind    (out_kind),
      .out_idx     (out_idx),
      .out_val     (out_val),
      .out_held    (out_held),
      .out_last    (out_last)
   );

   // pack the result register onto the stream
   assign rsp_tdata = {6'd0, out_held, out_val, out_idx};
   assign rsp_tuser = out_kind;
   assign rsp_tlast = out_last;

endmodule

// ===== rtl/swfr_checker.sv =====
// port-level checks for the sync word frame receiver core, with its bind
// depends on swfr_pkg and sync_word_frame_receiver_core
module swfr_checker import swfr_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [RSP_DW-1:0] rsp_tdata,
   input logic [0:0]        rsp_tuser,
   input logic              rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // no request is taken while results are pending
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && req_tready))
      else $error("request taken while result pending");

   // a discard is a single result with empty byte fields
   a_discard_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] == EV_DISCARD |->
      rsp_tlast && rsp_tdata[12:0] == 13'd0)
      else $error("malformed discard result");

   // the final frame byte carries last
   a_frame_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] == EV_FRAME_BYTE |->
      rsp_tlast == (rsp_tdata[4:0] == PKT_LAST_C))
      else $error("last marker misplaced in frame");

   // frame bytes follow in index order without gaps
   a_frame_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
      rsp_tvalid && rsp_tdata[4:0] == $past(rsp_tdata[4:0]) + 5'd1)
      else $error("frame byte index out of order");

endmodule

bind sync_word_frame_receiver_core swfr_checker u_swfr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
